### hdl/base64_mime_line_encoder_top_assert.svh
// Assertion macros used by the checker file of the base64 line encoder.
`ifndef BASE64_MIME_LINE_ENCODER_TOP_ASSERT_SVH
`define BASE64_MIME_LINE_ENCODER_TOP_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define B64L_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define B64L_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/b64l_pkg.sv
// Shared types and constants of the base64 line encoder.
`timescale 1ns / 1ps
package b64l_pkg;

  // Input bytes on one output line.
  localparam int LineBytes = 57;
  // Entries in the queue between the front and back parts.
  localparam int QDepth = 2;
  // Most characters that one input byte can produce.
  localparam int MaxChars = 5;

  localparam logic [7:0] CharPad = 8'h3D;
  localparam logic [7:0] CharLf  = 8'h0A;

  // One classified byte: the characters it yields, how many, and whether
  // the last of them ends the message.
  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [2:0]               num;
    logic                     fin;
  } entry_t;

endpackage

### hdl/b64l_front.sv
// Front part: accepts input bytes, tracks group and line position, and builds character entries.
`timescale 1ns / 1ps
module b64l_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output logic              push_o,
  output b64l_pkg::entry_t  entry_o,
  input  logic              full_i
);

  typedef enum logic [1:0] {
    PhEmpty = 2'd0,
    PhOne   = 2'd1,
    PhTwo   = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] pend_q, pend_d;
  logic [5:0]  cnt_q, cnt_d;

  logic [6:0]  count;
  logic        end_line;
  logic [7:0]  a_byte;
  logic [7:0]  p_byte;

  function automatic logic [7:0] sextet(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  assign count    = {1'b0, cnt_q} + 7'd1;
  assign end_line = last_byte_i || (count >= 7'(b64l_pkg::LineBytes));
  assign a_byte   = pend_q[15:8];
  assign p_byte   = pend_q[7:0];

  always_comb begin
    entry_o     = '0;
    entry_o.fin = last_byte_i;
    phase_d     = phase_q;
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    unique case (phase_q)
      PhOne: begin
        entry_o.chars[0] = sextet({a_byte[1:0], data_byte_i[7:4]});
        if (end_line) begin
          entry_o.chars[1] = sextet({data_byte_i[3:0], 2'b00});
          entry_o.chars[2] = b64l_pkg::CharPad;
          entry_o.num      = 3'd3;
        end else begin
          entry_o.num = 3'd1;
          pend_d      = {a_byte, data_byte_i};
          phase_d     = PhTwo;
        end
      end
      PhTwo: begin
        entry_o.chars[0] = sextet({p_byte[3:0], data_byte_i[7:6]});
        entry_o.chars[1] = sextet(data_byte_i[5:0]);
        entry_o.num      = 3'd2;
        pend_d           = '0;
        phase_d          = PhEmpty;
      end
      default: begin
        // An empty group, and the unused phase code, start a new group.
        entry_o.chars[0] = sextet(data_byte_i[7:2]);
        if (end_line) begin
          entry_o.chars[1] = sextet({data_byte_i[1:0], 4'b0000});
          entry_o.chars[2] = b64l_pkg::CharPad;
          entry_o.chars[3] = b64l_pkg::CharPad;
          entry_o.num      = 3'd4;
        end else begin
          entry_o.num = 3'd1;
          pend_d      = {data_byte_i, 8'h00};
          phase_d     = PhOne;
        end
      end
    endcase
    if (end_line) begin
      entry_o.chars[entry_o.num] = b64l_pkg::CharLf;
      entry_o.num                = entry_o.num + 3'd1;
      pend_d                     = '0;
      phase_d                    = PhEmpty;
      cnt_d                      = '0;
    end else begin
      cnt_d = count[5:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhEmpty;
      pend_q  <= '0;
      cnt_q   <= '0;
    end else if (push_o) begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### hdl/b64l_fifo.sv
// Short queue of character entries between the front and back parts.
`timescale 1ns / 1ps
module b64l_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  b64l_pkg::entry_t  wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output b64l_pkg::entry_t  rdata_o,
  output logic              valid_o
);

  localparam int Depth = b64l_pkg::QDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  b64l_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### hdl/b64l_back.sv
// Back part: takes entries from the queue and sends their characters one per transfer.
`timescale 1ns / 1ps
module b64l_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  b64l_pkg::entry_t  q_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_char_o,
  output logic              last_char_o
);

  b64l_pkg::entry_t cur_q;
  logic [2:0]       idx_q;
  logic             busy_q;
  logic             last_idx;
  logic             xfer;

  assign last_idx    = (idx_q == cur_q.num - 3'd1);
  assign xfer        = busy_q && out_ready_i;
  // A new entry loads when the register is empty or its final character leaves now.
  assign pop_o       = q_valid_i && (!busy_q || (xfer && last_idx));

  assign out_valid_o = busy_q;
  assign out_char_o  = cur_q.chars[idx_q];
  assign last_char_o = cur_q.fin && last_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (xfer) begin
      if (last_idx) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_data_i;
    end
  end

endmodule

### hdl/base64_mime_line_encoder_top.sv
// Top level of the base64 encoder with line breaks after every 57 input bytes.
`timescale 1ns / 1ps
// Each accepted byte is classified in the cycle of its transfer and yields one to five
// characters (base64 symbols, '=' pads and line feeds); a two-entry queue holds these
// groups and an output register sends one character per cycle unless out_ready_i stalls
// it. An input byte is taken in every cycle in which the queue has room, so the sustained
// input rate is set by the output side and by how many characters each byte yields.
// last_char_o marks the line feed that ends a message, after which group and line state
// start again from zero. There is no clearing pass after reset.
module base64_mime_line_encoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       last_char_o
);

  b64l_pkg::entry_t push_entry;
  b64l_pkg::entry_t pop_entry;
  logic             push;
  logic             pop;
  logic             full;
  logic             q_valid;

  b64l_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (push),
    .entry_o     (push_entry),
    .full_i      (full)
  );

  b64l_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (pop_entry),
    .valid_o (q_valid)
  );

  b64l_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule

### hdl/b64l_checker.sv
// Port-level checks of the base64 line encoder and their binding to the top level.
`timescale 1ns / 1ps
`include "base64_mime_line_encoder_top_assert.svh"
module b64l_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_char_o,
  input logic       last_char_o
);

  // A character that is offered stays offered until its transfer.
  `B64L_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o) && $stable(last_char_o),
    "output dropped or changed while stalled")

  // The end of a message is always marked on a line feed.
  `B64L_ASSERT(a_last_is_lf, clk_i, rst_ni,
    out_valid_o && last_char_o |-> out_char_o == b64l_pkg::CharLf,
    "end of message not on a line feed")

  // Every character is from the alphabet, a pad or a line feed.
  `B64L_ASSERT(a_char_legal, clk_i, rst_ni,
    out_valid_o |-> (out_char_o >= 8'h41 && out_char_o <= 8'h5A) ||
      (out_char_o >= 8'h61 && out_char_o <= 8'h7A) ||
      (out_char_o >= 8'h30 && out_char_o <= 8'h39) ||
      out_char_o == 8'h2B || out_char_o == 8'h2F ||
      out_char_o == b64l_pkg::CharPad || out_char_o == b64l_pkg::CharLf,
    "illegal output character")

  // Once reset has been seen at an edge, nothing is offered at the next one.
  `B64L_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o, "output valid during reset")

endmodule

bind base64_mime_line_encoder_top b64l_checker u_b64l_checker (.*);

### tb/base64_mime_line_encoder_checker.sv
// Scoreboard for the base64 line encoder: predicts the character stream and checks it.
`timescale 1ns / 1ps
module base64_mime_line_encoder_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_char_i,
  input  logic       last_char_i,
  output int         fail_count_o,
  output int         chars_due_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } b64_char_t;

  b64_char_t   char_q[$];
  logic [15:0] held_bytes;
  logic [1:0]  grp_phase;
  logic [5:0]  line_cnt;
  int          fails = 0;
  int          chars_seen = 0;

  // Standard alphabet: A-Z, a-z, 0-9, then plus and slash.
  function automatic logic [7:0] b64_symbol(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (w < 8'd26) begin
      return 8'h41 + w;
    end else if (w < 8'd52) begin
      return 8'h61 + (w - 8'd26);
    end else if (w < 8'd62) begin
      return 8'h30 + (w - 8'd52);
    end else if (w == 8'd62) begin
      return 8'h2B;
    end
    return 8'h2F;
  endfunction

  function automatic b64_char_t mk_char(input logic [7:0] c, input logic f);
    b64_char_t r;
    r.ch  = c;
    r.fin = f;
    return r;
  endfunction

  // Appends one predicted character at the tail of the expected stream.
  function automatic void add_char(input logic [7:0] c, input logic f);
    char_q = {char_q, mk_char(c, f)};
  endfunction

  // Updates the encoder state for one byte and queues the characters it completes.
  task automatic encode_byte(input logic [7:0] b, input logic lst);
    logic [6:0] cnt;
    logic       end_line;
    logic [7:0] a;
    cnt      = {1'b0, line_cnt} + 7'd1;
    end_line = lst || (cnt >= 7'(b64l_pkg::LineBytes));
    case (grp_phase)
      2'd1: begin
        a = held_bytes[15:8];
        add_char(b64_symbol({a[1:0], b[7:4]}), 1'b0);
        if (end_line) begin
          add_char(b64_symbol({b[3:0], 2'b00}), 1'b0);
          add_char(b64l_pkg::CharPad, 1'b0);
        end else begin
          held_bytes = {a, b};
          grp_phase  = 2'd2;
        end
      end
      2'd2: begin
        add_char(b64_symbol({held_bytes[3:0], b[7:6]}), 1'b0);
        add_char(b64_symbol(b[5:0]), 1'b0);
        held_bytes = '0;
        grp_phase  = 2'd0;
      end
      default: begin
        // A phase of three is handled like an empty group.
        add_char(b64_symbol(b[7:2]), 1'b0);
        if (end_line) begin
          add_char(b64_symbol({b[1:0], 4'b0000}), 1'b0);
          add_char(b64l_pkg::CharPad, 1'b0);
          add_char(b64l_pkg::CharPad, 1'b0);
        end else begin
          held_bytes = {b, 8'h00};
          grp_phase  = 2'd1;
        end
      end
    endcase
    if (end_line) begin
      add_char(b64l_pkg::CharLf, lst);
      held_bytes = '0;
      grp_phase  = '0;
      line_cnt   = '0;
    end else begin
      line_cnt = cnt[5:0];
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    b64_char_t want;
    if (!rst_ni) begin
      char_q.delete();
      held_bytes = '0;
      grp_phase  = '0;
      line_cnt   = '0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        encode_byte(data_byte_i, last_byte_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (char_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t: unexpected character %h, last %b", $time, out_char_i, last_char_i);
          end
        end else begin
          want = char_q.pop_front();
          if (want.ch !== out_char_i || want.fin !== last_char_i) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: character %0d expected %h last %b, got %h last %b", $time,
                       chars_seen, want.ch, want.fin, out_char_i, last_char_i);
            end
          end
        end
        chars_seen++;
      end
    end
    // Nonblocking so the stimulus side always sees the count of the previous edge.
    fail_count_o <= fails;
    chars_due_o  <= char_q.size();
  end

endmodule

### tb/base64_mime_line_encoder_top_tb.sv
// Testbench top of the base64 line encoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module base64_mime_line_encoder_top_tb;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid    = 1'b0;
  logic [7:0] data_byte   = 8'h00;
  logic       last_byte   = 1'b0;
  logic       out_ready   = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_char;
  logic       last_char;
  int         fail_count;
  int         chars_due;

  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int bytes_sent = 0;
  int cycle_cnt  = 0;

  always #6 clk_i = ~clk_i;

  base64_mime_line_encoder_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .data_byte_i (data_byte),
    .last_byte_i (last_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_char_o  (out_char),
    .last_char_o (last_char)
  );

  base64_mime_line_encoder_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .data_byte_i  (data_byte),
    .last_byte_i  (last_byte),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_char_i   (out_char),
    .last_char_i  (last_char),
    .fail_count_o (fail_count),
    .chars_due_o  (chars_due)
  );

  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    do @(posedge clk_i); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom), i == len - 1);
    end
  endtask

  // Mostly short messages, with some that reach or cross one and two line ends.
  function automatic int pick_length();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom_range(1, 6);
    if (sel < 7) return $urandom_range(7, 30);
    if (sel < 9) return $urandom_range(55, 60);
    return $urandom_range(112, 116);
  endfunction

  // Keeps a message within the bytes left for the current stretch.
  function automatic int cap_length(input int len, input int room);
    return (len < room) ? len : room;
  endfunction

  // The sender stops offering and waits until every expected character has come.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (chars_due != 0);
  endtask

  // Receiver: ready bursts, random stalls, and one long hold-off on request.
  initial begin
    int held;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        held = 0;
        while (held < HoldCycles) begin
          @(posedge clk_i);
          held++;
        end
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[base64_mime_line_encoder_top] ERROR");
    $finish;
  end

  initial begin
    int msgs;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One-byte messages: a full pad pair, with all-zero and all-one data.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // Two bytes: single pad.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Three bytes: a complete group, no pad.
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h0F, 1'b1);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h7E, 1'b1);

    // Sender waits until the whole directed stream has come out.
    drain_results();

    // The receiver holds off while a message that crosses a line end keeps coming.
    hold_req = 1'b1;
    send_message(58);
    drain_results();

    msgs = 0;
    while (bytes_sent < 200) begin
      send_message(cap_length(pick_length(), 200 - bytes_sent));
      msgs++;
      if (msgs % 4 == 0) begin
        drain_results();
      end
    end

    // Closing stretch at full rate on both sides.
    idle_on = 1'b0;
    while (bytes_sent < 260) begin
      send_message(cap_length(pick_length(), 260 - bytes_sent));
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && chars_due == 0) begin
      $display("[base64_mime_line_encoder_top] OK");
    end else begin
      $display("[base64_mime_line_encoder_top] ERROR");
    end
    $finish;
  end

endmodule
